// File: hw/rtl/sfe_pkg.sv
`timescale 1ns / 1ps

package sfe_pkg;

  // payload store geometry
  localparam int MAX_PAYLOAD = 1024;
  localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
  localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);

  // item modes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_PULL = 1'b1;

  // slip framing codes
  localparam logic [7:0] FR_END     = 8'hC0;
  localparam logic [7:0] FR_ESC     = 8'hDB;
  localparam logic [7:0] FR_ESC_END = 8'hDC;
  localparam logic [7:0] FR_ESC_ESC = 8'hDD;

  // crc-16/ccitt-false
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // header byte positions
  localparam logic [2:0] HDR_LEN_LO = 3'd0;
  localparam logic [2:0] HDR_LEN_HI = 3'd1;
  localparam logic [2:0] HDR_CRC_LO = 3'd2;
  localparam logic [2:0] HDR_CRC_HI = 3'd3;
  localparam logic [2:0] HDR_CMD    = 3'd4;
  localparam logic [2:0] HDR_ID_LO  = 3'd5;
  localparam logic [2:0] HDR_LAST   = 3'd6;

  // one byte of crc, msb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // little-endian unescaped header
  function automatic logic [7:0] header_byte(input logic [2:0] pos,
                                             input logic [LEN_W-1:0] len,
                                             input logic [15:0] crc,
                                             input logic [7:0] cmd,
                                             input logic [15:0] id);
    logic [15:0] len16;
    logic [7:0]  b;
    len16 = 16'(len);
    case (pos)
      HDR_LEN_LO: b = len16[7:0];
      HDR_LEN_HI: b = len16[15:8];
      HDR_CRC_LO: b = crc[7:0];
      HDR_CRC_HI: b = crc[15:8];
      HDR_CMD:    b = cmd;
      HDR_ID_LO:  b = id[7:0];
      default:    b = id[15:8];
    endcase
    return b;
  endfunction

endpackage

// File: hw/rtl/slip_frame_encoder_crc16_unit.sv
`timescale 1ns / 1ps

// SLIP frame encoder with CRC-16/CCITT-FALSE. Busy never rises, so start may
// be held high every cycle. A load item (mode 0) stores a payload byte and
// updates the CRC unless no_byte is set; the one with last_byte set also
// latches command and closes the packet. Each pull item (mode 1) gives one
// result, strobed by done on the cycle after it is taken: END, a 7-byte
// little-endian header, the escaped payload and a closing END marked by
// frame_end. The receiver cannot stall, so done must be sampled on every
// cycle. The payload store has a registered read port, and its address
// follows the next emit position so the byte is already there when the
// next pull comes. Load items are ignored while a frame is pending; bytes
// beyond the buffer are dropped and raise overflow.
module slip_frame_encoder_crc16_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       mode,
  input  logic [7:0] payload_byte,
  input  logic       last_byte,
  input  logic       no_byte,
  input  logic [7:0] command,
  output logic       done,
  output logic [7:0] out_byte,
  output logic       out_valid,
  output logic       frame_end,
  output logic       overflow
);

  localparam logic [1:0] PH_LOAD   = 2'd0;
  localparam logic [1:0] PH_START  = 2'd1;
  localparam logic [1:0] PH_HEADER = 2'd2;
  localparam logic [1:0] PH_BODY   = 2'd3;

  localparam logic [sfe_pkg::LEN_W-1:0] MAX_LEN = sfe_pkg::LEN_W'(sfe_pkg::MAX_PAYLOAD);

  logic [1:0]                  phase, phase_next;
  logic [sfe_pkg::LEN_W-1:0]   length, length_next;
  logic [sfe_pkg::LEN_W-1:0]   pos, pos_next;
  logic [15:0]                 crc, crc_next;
  logic [15:0]                 packet_id, packet_id_next;
  logic [7:0]                  cmd_latch, cmd_latch_next;
  logic                        esc_pending, esc_pending_next;
  logic                        ovf_flag, ovf_flag_next;

  logic                        accept;
  logic                        store_we;
  logic [7:0]                  store_rdata;
  logic [7:0]                  res_byte;
  logic                        res_valid;
  logic                        res_end;

  // one item per cycle, never stalled
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // store writes only while loading and with room left
  assign store_we = accept && (mode == sfe_pkg::MODE_LOAD) && (phase == PH_LOAD) &&
                    !no_byte && (length < MAX_LEN);

  sfe_ram #(
    .WIDTH(8),
    .DEPTH(sfe_pkg::MAX_PAYLOAD)
  ) u_store (
    .clk  (clk),
    .we   (store_we),
    .waddr(length[sfe_pkg::ADDR_W-1:0]),
    .wdata(payload_byte),
    .raddr(pos_next[sfe_pkg::ADDR_W-1:0]),
    .rdata(store_rdata)
  );

  // load and emit sequencing
  always_comb begin
    phase_next       = phase;
    length_next      = length;
    pos_next         = pos;
    crc_next         = crc;
    packet_id_next   = packet_id;
    cmd_latch_next   = cmd_latch;
    esc_pending_next = esc_pending;
    ovf_flag_next    = ovf_flag;
    res_byte         = 8'h00;
    res_valid        = 1'b0;
    res_end          = 1'b0;

    if (accept && mode == sfe_pkg::MODE_LOAD) begin
      if (phase == PH_LOAD) begin
        if (!no_byte) begin
          if (length < MAX_LEN) begin
            length_next = length + 1'b1;
            crc_next    = sfe_pkg::crc_byte(crc, payload_byte);
          end else begin
            ovf_flag_next = 1'b1;
          end
        end
        if (last_byte) begin
          cmd_latch_next   = command;
          phase_next       = PH_START;
          pos_next         = '0;
          esc_pending_next = 1'b0;
        end
      end
    end else if (accept && mode == sfe_pkg::MODE_PULL) begin
      unique case (phase)
        PH_START: begin
          res_byte   = sfe_pkg::FR_END;
          res_valid  = 1'b1;
          phase_next = PH_HEADER;
          pos_next   = '0;
        end
        PH_HEADER: begin
          res_byte  = sfe_pkg::header_byte(pos[2:0], length, crc, cmd_latch, packet_id);
          res_valid = 1'b1;
          if (pos[2:0] == sfe_pkg::HDR_LAST) begin
            phase_next       = PH_BODY;
            pos_next         = '0;
            esc_pending_next = 1'b0;
          end else begin
            pos_next = pos + 1'b1;
          end
        end
        PH_BODY: begin
          res_valid = 1'b1;
          if (pos >= length || pos >= MAX_LEN) begin
            // closing END, back to loading
            res_byte         = sfe_pkg::FR_END;
            res_end          = 1'b1;
            packet_id_next   = packet_id + 16'd1;
            length_next      = '0;
            crc_next         = sfe_pkg::CRC_INIT;
            phase_next       = PH_LOAD;
            pos_next         = '0;
            esc_pending_next = 1'b0;
            ovf_flag_next    = 1'b0;
          end else if (store_rdata == sfe_pkg::FR_END || store_rdata == sfe_pkg::FR_ESC) begin
            // two-byte escape sequence
            if (!esc_pending) begin
              res_byte         = sfe_pkg::FR_ESC;
              esc_pending_next = 1'b1;
            end else begin
              res_byte = (store_rdata == sfe_pkg::FR_END) ? sfe_pkg::FR_ESC_END
                                                          : sfe_pkg::FR_ESC_ESC;
              esc_pending_next = 1'b0;
              pos_next         = pos + 1'b1;
            end
          end else begin
            res_byte = store_rdata;
            pos_next = pos + 1'b1;
          end
        end
        default: begin
          // pull while loading gives an empty result
          res_valid = 1'b0;
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_LOAD;
      length      <= '0;
      pos         <= '0;
      crc         <= sfe_pkg::CRC_INIT;
      packet_id   <= '0;
      cmd_latch   <= '0;
      esc_pending <= 1'b0;
      ovf_flag    <= 1'b0;
      done        <= 1'b0;
    end else begin
      phase       <= phase_next;
      length      <= length_next;
      pos         <= pos_next;
      crc         <= crc_next;
      packet_id   <= packet_id_next;
      cmd_latch   <= cmd_latch_next;
      esc_pending <= esc_pending_next;
      ovf_flag    <= ovf_flag_next;
      done        <= accept && (mode == sfe_pkg::MODE_PULL);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (accept && mode == sfe_pkg::MODE_PULL) begin
      out_byte  <= res_byte;
      out_valid <= res_valid;
      frame_end <= res_end;
      overflow  <= ovf_flag;
    end
  end

endmodule

// File: hw/rtl/sfe_ram.sv
`timescale 1ns / 1ps

module sfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/sfe_checker.sv
`timescale 1ns / 1ps

module sfe_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       mode,
  input logic [7:0] payload_byte,
  input logic       last_byte,
  input logic       no_byte,
  input logic [7:0] command,
  input logic       done,
  input logic [7:0] out_byte,
  input logic       out_valid,
  input logic       frame_end,
  input logic       overflow
);

  // every pull gives exactly one result on the next cycle
  a_pull_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && mode == sfe_pkg::MODE_PULL) |=> done)
    else $error("pull item without result");

  // load items give no result
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && mode == sfe_pkg::MODE_LOAD) |=> !done)
    else $error("result after load item");

  // closing byte is a valid END
  a_end_byte: assert property (@(posedge clk) disable iff (rst)
    (done && frame_end) |-> (out_valid && out_byte == sfe_pkg::FR_END))
    else $error("frame end without END byte");

  // a pull with no frame ready gives a zero byte and no frame end
  a_empty_pull: assert property (@(posedge clk) disable iff (rst)
    (done && !out_valid) |-> (out_byte == 8'h00 && !frame_end))
    else $error("empty result not clean");

endmodule

bind slip_frame_encoder_crc16_unit sfe_checker u_sfe_checker (.*);

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int   STALL_LIMIT = 2000;
  localparam int   RANDOM_ITEMS = 400;

  typedef enum logic [1:0] {ENC_LOAD, ENC_START, ENC_HEADER, ENC_BODY} enc_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       fend;
    logic       ovf;
  } frame_byte_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       start;
  logic       busy;
  logic       mode;
  logic [7:0] payload_byte;
  logic       last_byte;
  logic       no_byte;
  logic [7:0] command;
  logic       done;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       frame_end;
  logic       overflow;

  // encoder shadow state
  logic [7:0]                shadow_store [sfe_pkg::MAX_PAYLOAD];
  logic [sfe_pkg::LEN_W-1:0] shadow_len;
  logic [15:0]               shadow_crc;
  logic [15:0]               shadow_id;
  logic [7:0]                shadow_cmd;
  enc_phase_t                enc_phase;
  logic [2:0]                hdr_idx;
  logic [sfe_pkg::LEN_W-1:0] body_pos;
  logic                      esc_pending;
  logic                      shadow_ovf;

  frame_byte_t expected_bytes [$];
  frame_byte_t want;
  int          errors = 0;
  int          items_sent = 0;
  int          gap_max = 15;
  int          idle_cycles = 0;
  int          drain_wait;

  slip_frame_encoder_crc16_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .payload_byte (payload_byte),
    .last_byte    (last_byte),
    .no_byte      (no_byte),
    .command      (command),
    .done         (done),
    .out_byte     (out_byte),
    .out_valid    (out_valid),
    .frame_end    (frame_end),
    .overflow     (overflow)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    if (errors < 50) begin
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, exp_val);
    end
    errors++;
  endtask

  // crc-16/ccitt-false, one input bit at a time
  function automatic logic [15:0] crc_ccitt_update(input logic [15:0] crc_in,
                                                   input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc_in;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0} ^ (fb ? sfe_pkg::CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  // advance the shadow encoder by one accepted item, queue the byte it gives
  task automatic slip_encode_step(input logic m, input logic [7:0] pb, input logic lb,
                                  input logic nb, input logic [7:0] cmd);
    frame_byte_t r;
    logic [15:0] len16;
    logic [7:0]  c;
    if (m == sfe_pkg::MODE_LOAD) begin
      if (enc_phase == ENC_LOAD) begin
        if (!nb) begin
          if (shadow_len < sfe_pkg::MAX_PAYLOAD) begin
            shadow_store[shadow_len[sfe_pkg::ADDR_W-1:0]] = pb;
            shadow_len++;
            shadow_crc = crc_ccitt_update(shadow_crc, pb);
          end else begin
            shadow_ovf = 1'b1;
          end
        end
        if (lb) begin
          shadow_cmd = cmd;
          enc_phase = ENC_START;
        end
      end
    end else begin
      r = '0;
      r.ovf = shadow_ovf;
      len16 = 16'(shadow_len);
      case (enc_phase)
        ENC_LOAD: ;
        ENC_START: begin
          r.data = sfe_pkg::FR_END;
          r.valid = 1'b1;
          enc_phase = ENC_HEADER;
          hdr_idx = sfe_pkg::HDR_LEN_LO;
        end
        ENC_HEADER: begin
          r.valid = 1'b1;
          case (hdr_idx)
            sfe_pkg::HDR_LEN_LO: r.data = len16[7:0];
            sfe_pkg::HDR_LEN_HI: r.data = len16[15:8];
            sfe_pkg::HDR_CRC_LO: r.data = shadow_crc[7:0];
            sfe_pkg::HDR_CRC_HI: r.data = shadow_crc[15:8];
            sfe_pkg::HDR_CMD:    r.data = shadow_cmd;
            sfe_pkg::HDR_ID_LO:  r.data = shadow_id[7:0];
            default:             r.data = shadow_id[15:8];
          endcase
          if (hdr_idx == sfe_pkg::HDR_LAST) begin
            enc_phase = ENC_BODY;
            body_pos = '0;
            esc_pending = 1'b0;
          end else begin
            hdr_idx++;
          end
        end
        default: begin
          r.valid = 1'b1;
          if (body_pos >= shadow_len) begin
            // closing end, back to loading
            r.data = sfe_pkg::FR_END;
            r.fend = 1'b1;
            shadow_id++;
            shadow_len = '0;
            shadow_crc = sfe_pkg::CRC_INIT;
            enc_phase = ENC_LOAD;
            body_pos = '0;
            esc_pending = 1'b0;
            shadow_ovf = 1'b0;
          end else begin
            c = shadow_store[body_pos[sfe_pkg::ADDR_W-1:0]];
            if (c == sfe_pkg::FR_END || c == sfe_pkg::FR_ESC) begin
              if (!esc_pending) begin
                r.data = sfe_pkg::FR_ESC;
                esc_pending = 1'b1;
              end else begin
                r.data = (c == sfe_pkg::FR_END) ? sfe_pkg::FR_ESC_END : sfe_pkg::FR_ESC_ESC;
                esc_pending = 1'b0;
                body_pos++;
              end
            end else begin
              r.data = c;
              body_pos++;
            end
          end
        end
      endcase
      expected_bytes.push_back(r);
    end
  endtask

  // drive one item after a random gap and wait until it is taken
  task automatic send_item(input logic m, input logic [7:0] pb, input logic lb,
                           input logic nb, input logic [7:0] cmd);
    int gap;
    gap = $urandom_range(gap_max);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    mode         <= m;
    payload_byte <= pb;
    last_byte    <= lb;
    no_byte      <= nb;
    command      <= cmd;
    do @(posedge clk); while (busy);
    items_sent++;
    slip_encode_step(m, pb, lb, nb, cmd);
  endtask

  task automatic pull_item();
    send_item(sfe_pkg::MODE_PULL, 8'($urandom), 1'($urandom), 1'($urandom), 8'($urandom));
  endtask

  // payload byte biased toward the framing codes
  function automatic logic [7:0] rand_payload();
    logic [7:0] b;
    case ($urandom_range(7))
      0: b = sfe_pkg::FR_END;
      1: b = sfe_pkg::FR_ESC;
      2: b = ($urandom_range(1) == 0) ? sfe_pkg::FR_ESC_END : sfe_pkg::FR_ESC_ESC;
      default: b = 8'($urandom);
    endcase
    return b;
  endfunction

  // pull until the frame is out, with optional ignored loads mixed in
  task automatic drain_frame(input int noise_one_in);
    while (enc_phase != ENC_LOAD) begin
      if (noise_one_in > 0 && $urandom_range(noise_one_in - 1) == 0) begin
        send_item(sfe_pkg::MODE_LOAD, rand_payload(), 1'($urandom), 1'($urandom),
                  8'($urandom));
      end else begin
        pull_item();
      end
    end
  endtask

  task automatic test_pull_while_loading();
    gap_max = 15;
    pull_item();
    pull_item();
  endtask

  task automatic test_empty_packet();
    gap_max = 0;
    send_item(sfe_pkg::MODE_LOAD, 8'hA5, 1'b1, 1'b1, 8'hFF);
    // load while a frame is pending is ignored
    send_item(sfe_pkg::MODE_LOAD, 8'h11, 1'b1, 1'b0, 8'h00);
    drain_frame(0);
  endtask

  task automatic test_escaped_payload();
    gap_max = 15;
    send_item(sfe_pkg::MODE_LOAD, sfe_pkg::FR_END, 1'b0, 1'b0, 8'hFF);
    send_item(sfe_pkg::MODE_LOAD, 8'h00, 1'b0, 1'b1, 8'hFF);
    send_item(sfe_pkg::MODE_LOAD, sfe_pkg::FR_ESC, 1'b0, 1'b0, 8'h00);
    send_item(sfe_pkg::MODE_LOAD, 8'hFF, 1'b1, 1'b0, 8'h00);
    drain_frame(0);
  endtask

  task automatic test_random_frames();
    int n;
    while (items_sent < RANDOM_ITEMS) begin
      gap_max = ($urandom_range(3) == 0) ? 0 : 15;
      n = ($urandom_range(7) == 0) ? 0 : $urandom_range(12);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(9) == 0) begin
          // noise: pull while loading or a load with no byte
          if ($urandom_range(1) == 0) pull_item();
          else send_item(sfe_pkg::MODE_LOAD, 8'($urandom), 1'b0, 1'b1, 8'($urandom));
        end else begin
          send_item(sfe_pkg::MODE_LOAD, rand_payload(), 1'b0, 1'b0, 8'($urandom));
        end
      end
      send_item(sfe_pkg::MODE_LOAD, rand_payload(), 1'b1, 1'($urandom), 8'($urandom));
      drain_frame(10);
    end
  endtask

  task automatic test_overflow();
    gap_max = 0;
    for (int i = 0; i < sfe_pkg::MAX_PAYLOAD + 3; i++) begin
      send_item(sfe_pkg::MODE_LOAD, 8'($urandom), 1'b0, 1'b0, 8'($urandom));
    end
    // pull while loading shows the overflow flag
    pull_item();
    send_item(sfe_pkg::MODE_LOAD, 8'h5A, 1'b1, 1'b0, 8'h3C);
    drain_frame(0);
    // next frame starts clean
    send_item(sfe_pkg::MODE_LOAD, 8'h01, 1'b1, 1'b0, 8'h80);
    drain_frame(0);
  endtask

  // result checker, done is a one-cycle strobe
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch("result with nothing pending", out_byte, 0);
      end else begin
        want = expected_bytes.pop_front();
        if (out_byte !== want.data) report_mismatch("out_byte", out_byte, want.data);
        if (out_valid !== want.valid) report_mismatch("out_valid", out_valid, want.valid);
        if (frame_end !== want.fend) report_mismatch("frame_end", frame_end, want.fend);
        if (overflow !== want.ovf) report_mismatch("overflow", overflow, want.ovf);
      end
    end
  end

  // watchdog on cycles with no progress
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("slip_frame_encoder_crc16_unit test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst          <= 1'b1;
    start        <= 1'b0;
    mode         <= sfe_pkg::MODE_LOAD;
    payload_byte <= 8'h00;
    last_byte    <= 1'b0;
    no_byte      <= 1'b0;
    command      <= 8'h00;
    shadow_len   = '0;
    shadow_crc   = sfe_pkg::CRC_INIT;
    shadow_id    = '0;
    shadow_cmd   = '0;
    enc_phase    = ENC_LOAD;
    hdr_idx      = sfe_pkg::HDR_LEN_LO;
    body_pos     = '0;
    esc_pending  = 1'b0;
    shadow_ovf   = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_pull_while_loading();
    test_empty_packet();
    test_escaped_payload();
    test_random_frames();
    test_overflow();

    start <= 1'b0;
    drain_wait = 0;
    while (expected_bytes.size() > 0 && drain_wait < 100) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (4) @(posedge clk);
    if (expected_bytes.size() != 0) begin
      report_mismatch("results never delivered", 0, expected_bytes.size());
    end

    if (errors == 0) begin
      $display("slip_frame_encoder_crc16_unit test passed");
    end else begin
      $display("slip_frame_encoder_crc16_unit test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/sfe_pkg.sv
hw/rtl/sfe_ram.sv
hw/rtl/slip_frame_encoder_crc16_unit.sv
hw/rtl/sfe_checker.sv
tb/tb_top.sv
